FILE: sv/lud_pkg.sv
// Package for the lens undistortion coordinate map.
// Holds widths, fixed-point constants, register indexes and saturation helpers.
// No dependencies.
package lud_pkg;

	localparam int PIX_W   = 11;  // output pixel column and row
	localparam int SRC_W   = 13;  // source column and row, signed
	localparam int FOC_W   = 20;  // focal lengths and principal point
	localparam int COEF_W  = 32;  // distortion coefficients, Q4.28
	localparam int CFG_W   = 32;  // widest register
	localparam int CFG_IDX_W = 3;

	localparam int Q_FRAC  = 28;
	localparam int DIV_STEPS = 32;            // quotient bits per normalization
	localparam int NORM_LAT  = DIV_STEPS + 2; // prep stage, quotient steps, sign stage

	localparam int DEF_IMAGE_WIDTH  = 752;
	localparam int DEF_IMAGE_HEIGHT = 480;

	typedef logic signed [31:0] q_t;
	typedef logic signed [SRC_W-1:0] src_t;

	localparam q_t Q_MAX = 32'sh7fff_ffff;
	localparam q_t Q_MIN = 32'sh8000_0000;
	localparam q_t Q_ONE = 32'sh1000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FOCAL_X    = 3'd0,
		REG_FOCAL_Y    = 3'd1,
		REG_CENTER_X   = 3'd2,
		REG_CENTER_Y   = 3'd3,
		REG_RADIAL_K1  = 3'd4,
		REG_RADIAL_K2  = 3'd5,
		REG_TANGENT_P1 = 3'd6,
		REG_TANGENT_P2 = 3'd7
	} cfg_reg_t;

	localparam logic [FOC_W-1:0]  RST_FOCAL_X    = 20'd117415;
	localparam logic [FOC_W-1:0]  RST_FOCAL_Y    = 20'd117068;
	localparam logic [FOC_W-1:0]  RST_CENTER_X   = 20'd94007;
	localparam logic [FOC_W-1:0]  RST_CENTER_Y   = 20'd63584;
	localparam logic [COEF_W-1:0] RST_RADIAL_K1  = 32'hfb77_290e;  // -76076786
	localparam logic [COEF_W-1:0] RST_RADIAL_K2  = 32'd19853236;
	localparam logic [COEF_W-1:0] RST_TANGENT_P1 = 32'd51966;
	localparam logic [COEF_W-1:0] RST_TANGENT_P2 = 32'd4730;

	// Clamp a 36 bit value to the Q4.28 range.
	function automatic q_t sat36(input logic signed [35:0] v);
		q_t r;
		if (!v[35] && (v[34:31] != 4'b0000)) begin
			r = Q_MAX;
		end else if (v[35] && (v[34:31] != 4'b1111)) begin
			r = Q_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Full product of two Q4.28 values back to Q4.28: the arithmetic shift
	// rounds toward minus infinity, then the result is clamped.
	function automatic q_t qsat_prod(input logic signed [63:0] p);
		return sat36(p[63:Q_FRAC]);
	endfunction

endpackage

FILE: sv/lud_if.sv
// Valid/ready channel interfaces of the lens undistortion coordinate map.
// Depends on lud_pkg for the field widths.
interface lud_pixel_if;
	logic                      valid;
	logic                      ready;
	logic [lud_pkg::PIX_W-1:0] out_col;
	logic [lud_pkg::PIX_W-1:0] out_row;

	modport source (output valid, output out_col, output out_row, input ready);
	modport sink   (input valid, input out_col, input out_row, output ready);
endinterface

interface lud_map_if;
	logic          valid;
	logic          ready;
	lud_pkg::src_t src_col;
	lud_pkg::src_t src_row;
	logic          src_inside;

	modport source (output valid, output src_col, output src_row, output src_inside,
		input ready);
	modport sink   (input valid, input src_col, input src_row, input src_inside,
		output ready);
endinterface

FILE: sv/lens_undistort_coordinate_map.sv
// Top level of the lens undistortion coordinate map (radial plus tangential model).
// Depends on lud_pkg, the channel interfaces in lud_if.sv and the lud_norm lanes.
//
//   channel   direction  word                              handshake
//   pixel     in         out_col, out_row                  valid / ready
//   mapped    out        src_col, src_row, src_inside      valid / ready
//   cfg       in         cfg_index, cfg_data               cfg_we, no wait
//
// One word enters per cycle while the skid register is empty. From acceptance to the
// output register a word passes the normalization dividers, whose 32 quotient steps
// each take one stage between a prep and a sign stage, and then the 14 multiply,
// clamp and add stages of the distortion polynomial and the mapping back to pixels.
// Reset clears the valid bits and the skid flag and loads the default
// lens registers. When the output stalls, the word leaving the last stage
// drops into a skid register and the whole pipeline holds on the next cycle;
// nothing is lost or repeated, and pixel.ready depends only on a flop.
module lens_undistort_coordinate_map #(
	parameter int IMAGE_WIDTH  = lud_pkg::DEF_IMAGE_WIDTH,
	parameter int IMAGE_HEIGHT = lud_pkg::DEF_IMAGE_HEIGHT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lud_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lud_pkg::CFG_W-1:0]         cfg_data,
	lud_pixel_if.sink                         pixel,
	lud_map_if.source                         mapped
);

	localparam int FW   = lud_pkg::FOC_W;
	localparam int CW   = lud_pkg::COEF_W;
	localparam int SW   = lud_pkg::SRC_W;
	localparam int LAT  = lud_pkg::NORM_LAT;
	localparam int FRAC = lud_pkg::Q_FRAC;
	localparam int PW   = FW + 1 + CW;       // focal times distorted coordinate
	localparam int NW   = PW + 1;            // plus the principal point term
	localparam int SHIFT = FRAC + 8;         // back to whole pixels
	localparam int FLW  = NW - SHIFT;        // width of the pixel value before clamping

	localparam logic signed [SW-1:0] COL_LIM = SW'(IMAGE_WIDTH);
	localparam logic signed [SW-1:0] ROW_LIM = SW'(IMAGE_HEIGHT);
	localparam logic signed [FLW-1:0] PIX_MAX = FLW'(4095);
	localparam logic signed [FLW-1:0] PIX_MIN = -FLW'(4096);

	// Lens registers.
	logic [FW-1:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
	lud_pkg::q_t   k1_q, k2_q, p1_q, p2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= lud_pkg::RST_FOCAL_X;
			focal_y_q  <= lud_pkg::RST_FOCAL_Y;
			center_x_q <= lud_pkg::RST_CENTER_X;
			center_y_q <= lud_pkg::RST_CENTER_Y;
			k1_q       <= lud_pkg::RST_RADIAL_K1;
			k2_q       <= lud_pkg::RST_RADIAL_K2;
			p1_q       <= lud_pkg::RST_TANGENT_P1;
			p2_q       <= lud_pkg::RST_TANGENT_P2;
		end else if (cfg_we) begin
			case (lud_pkg::cfg_reg_t'(cfg_index))
				lud_pkg::REG_FOCAL_X:    focal_x_q  <= cfg_data[FW-1:0];
				lud_pkg::REG_FOCAL_Y:    focal_y_q  <= cfg_data[FW-1:0];
				lud_pkg::REG_CENTER_X:   center_x_q <= cfg_data[FW-1:0];
				lud_pkg::REG_CENTER_Y:   center_y_q <= cfg_data[FW-1:0];
				lud_pkg::REG_RADIAL_K1:  k1_q       <= cfg_data[CW-1:0];
				lud_pkg::REG_RADIAL_K2:  k2_q       <= cfg_data[CW-1:0];
				lud_pkg::REG_TANGENT_P1: p1_q       <= cfg_data[CW-1:0];
				lud_pkg::REG_TANGENT_P2: p2_q       <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	// The pipeline advances as one while the skid register is empty.
	logic en;
	logic sk_v_q;

	assign en          = !sk_v_q;
	assign pixel.ready = en;

	// Normalization lanes; their results appear with norm_vld_s[LAT-1].
	lud_pkg::q_t x_n, y_n;

	lud_norm u_norm_x (
		.clk    (clk),
		.en     (en),
		.pix    (pixel.out_col),
		.center (center_x_q),
		.focal  (focal_x_q),
		.q      (x_n)
	);

	lud_norm u_norm_y (
		.clk    (clk),
		.en     (en),
		.pix    (pixel.out_row),
		.center (center_y_q),
		.focal  (focal_y_q),
		.q      (y_n)
	);

	// Valid bits travel alongside the data; stages below number from the
	// end of normalization.
	logic norm_vld_s [0:LAT-1];
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic vld_s8, vld_s9, vld_s10, vld_s11, vld_s12, vld_s13, vld_s14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) begin
				norm_vld_s[i] <= 1'b0;
			end
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
			vld_s14 <= 1'b0;
		end else if (en) begin
			norm_vld_s[0] <= pixel.valid;
			for (int i = 1; i < LAT; i++) begin
				norm_vld_s[i] <= norm_vld_s[i-1];
			end
			vld_s1  <= norm_vld_s[LAT-1];
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
			vld_s14 <= vld_s13;
		end
	end

	// Polynomial datapath. Multiply stages hold full products; the stage after
	// each one shifts them back to Q4.28 and clamps.
	logic signed [63:0] xx_p_s1, yy_p_s1, xy_p_s1;
	lud_pkg::q_t        x_s1, y_s1;
	lud_pkg::q_t        xx_s2, yy_s2, xy_s2, x_s2, y_s2;
	lud_pkg::q_t        r2_s3, xx2_s3, yy2_s3, xy_s3, x_s3, y_s3;
	logic signed [63:0] r4_p_s4, k1r2_p_s4, p1xy_p_s4, p2xy_p_s4;
	lud_pkg::q_t        sx_s4, sy_s4, x_s4, y_s4;
	lud_pkg::q_t        r4_s5, k1r2_s5, p1xy_s5, p2xy_s5, sx_s5, sy_s5, x_s5, y_s5;
	logic signed [63:0] k2r4_p_s6, tx_p_s6, ty_p_s6;
	lud_pkg::q_t        k1r2_s6, p1xy2_s6, p2xy2_s6, x_s6, y_s6;
	lud_pkg::q_t        k2r4_s7, tx_s7, ty_s7, k1r2_s7, p1xy2_s7, p2xy2_s7, x_s7, y_s7;
	lud_pkg::q_t        radial_s8, tx_s8, ty_s8, p1xy2_s8, p2xy2_s8, x_s8, y_s8;
	logic signed [63:0] xr_p_s9, yr_p_s9;
	lud_pkg::q_t        tx_s9, ty_s9, p1xy2_s9, p2xy2_s9;
	lud_pkg::q_t        xr_s10, yr_s10, tx_s10, ty_s10, p1xy2_s10, p2xy2_s10;
	lud_pkg::q_t        xd_s11, yd_s11;
	logic signed [PW-1:0] colp_s12, rowp_s12;
	logic signed [NW-1:0] coln_s13, rown_s13;
	lud_pkg::src_t      col_s14, row_s14;
	logic               ins_s14;

	// Back mapping: divide by 2^36 toward zero, then clamp to the output range.
	function automatic lud_pkg::src_t to_pix(input logic signed [NW-1:0] n);
		logic signed [FLW-1:0] fl;
		logic signed [FLW-1:0] p;
		lud_pkg::src_t         r;
		fl = n[NW-1:SHIFT];
		// A negative value with a fraction rounds up by one to truncate toward zero.
		p  = fl + $signed({{(FLW-1){1'b0}}, (n[NW-1] && (n[SHIFT-1:0] != '0))});
		if (p > PIX_MAX) begin
			r = PIX_MAX[SW-1:0];
		end else if (p < PIX_MIN) begin
			r = PIX_MIN[SW-1:0];
		end else begin
			r = p[SW-1:0];
		end
		return r;
	endfunction

	lud_pkg::src_t col_c, row_c;

	always_comb begin
		col_c = to_pix(coln_s13);
		row_c = to_pix(rown_s13);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Squares and cross term.
			xx_p_s1 <= x_n * x_n;
			yy_p_s1 <= y_n * y_n;
			xy_p_s1 <= x_n * y_n;
			x_s1    <= x_n;
			y_s1    <= y_n;

			xx_s2 <= lud_pkg::qsat_prod(xx_p_s1);
			yy_s2 <= lud_pkg::qsat_prod(yy_p_s1);
			xy_s2 <= lud_pkg::qsat_prod(xy_p_s1);
			x_s2  <= x_s1;
			y_s2  <= y_s1;

			// r squared and the doubled squares of the tangential terms.
			r2_s3  <= lud_pkg::sat36(36'(xx_s2) + 36'(yy_s2));
			xx2_s3 <= lud_pkg::sat36(36'(xx_s2) + 36'(xx_s2));
			yy2_s3 <= lud_pkg::sat36(36'(yy_s2) + 36'(yy_s2));
			xy_s3  <= xy_s2;
			x_s3   <= x_s2;
			y_s3   <= y_s2;

			r4_p_s4   <= r2_s3 * r2_s3;
			k1r2_p_s4 <= k1_q * r2_s3;
			p1xy_p_s4 <= p1_q * xy_s3;
			p2xy_p_s4 <= p2_q * xy_s3;
			sx_s4     <= lud_pkg::sat36(36'(r2_s3) + 36'(xx2_s3));
			sy_s4     <= lud_pkg::sat36(36'(r2_s3) + 36'(yy2_s3));
			x_s4      <= x_s3;
			y_s4      <= y_s3;

			r4_s5   <= lud_pkg::qsat_prod(r4_p_s4);
			k1r2_s5 <= lud_pkg::qsat_prod(k1r2_p_s4);
			p1xy_s5 <= lud_pkg::qsat_prod(p1xy_p_s4);
			p2xy_s5 <= lud_pkg::qsat_prod(p2xy_p_s4);
			sx_s5   <= sx_s4;
			sy_s5   <= sy_s4;
			x_s5    <= x_s4;
			y_s5    <= y_s4;

			k2r4_p_s6 <= k2_q * r4_s5;
			tx_p_s6   <= p2_q * sx_s5;
			ty_p_s6   <= p1_q * sy_s5;
			k1r2_s6   <= k1r2_s5;
			p1xy2_s6  <= lud_pkg::sat36(36'(p1xy_s5) + 36'(p1xy_s5));
			p2xy2_s6  <= lud_pkg::sat36(36'(p2xy_s5) + 36'(p2xy_s5));
			x_s6      <= x_s5;
			y_s6      <= y_s5;

			k2r4_s7  <= lud_pkg::qsat_prod(k2r4_p_s6);
			tx_s7    <= lud_pkg::qsat_prod(tx_p_s6);
			ty_s7    <= lud_pkg::qsat_prod(ty_p_s6);
			k1r2_s7  <= k1r2_s6;
			p1xy2_s7 <= p1xy2_s6;
			p2xy2_s7 <= p2xy2_s6;
			x_s7     <= x_s6;
			y_s7     <= y_s6;

			// Radial factor: one plus both terms, clamped once.
			radial_s8 <= lud_pkg::sat36(36'(lud_pkg::Q_ONE) + 36'(k1r2_s7) + 36'(k2r4_s7));
			tx_s8     <= tx_s7;
			ty_s8     <= ty_s7;
			p1xy2_s8  <= p1xy2_s7;
			p2xy2_s8  <= p2xy2_s7;
			x_s8      <= x_s7;
			y_s8      <= y_s7;

			xr_p_s9  <= x_s8 * radial_s8;
			yr_p_s9  <= y_s8 * radial_s8;
			tx_s9    <= tx_s8;
			ty_s9    <= ty_s8;
			p1xy2_s9 <= p1xy2_s8;
			p2xy2_s9 <= p2xy2_s8;

			xr_s10    <= lud_pkg::qsat_prod(xr_p_s9);
			yr_s10    <= lud_pkg::qsat_prod(yr_p_s9);
			tx_s10    <= tx_s9;
			ty_s10    <= ty_s9;
			p1xy2_s10 <= p1xy2_s9;
			p2xy2_s10 <= p2xy2_s9;

			// Distorted normalized coordinates.
			xd_s11 <= lud_pkg::sat36(36'(xr_s10) + 36'(p1xy2_s10) + 36'(tx_s10));
			yd_s11 <= lud_pkg::sat36(36'(yr_s10) + 36'(ty_s10) + 36'(p2xy2_s10));

			// Back to pixels: focal * xd + center * 2^28, in 1/2^36 pixel.
			colp_s12 <= $signed({1'b0, focal_x_q}) * xd_s11;
			rowp_s12 <= $signed({1'b0, focal_y_q}) * yd_s11;

			coln_s13 <= NW'(colp_s12) + $signed({{(NW-FW-FRAC){1'b0}}, center_x_q, {FRAC{1'b0}}});
			rown_s13 <= NW'(rowp_s12) + $signed({{(NW-FW-FRAC){1'b0}}, center_y_q, {FRAC{1'b0}}});

			col_s14 <= col_c;
			row_s14 <= row_c;
			ins_s14 <= !col_c[SW-1] && (col_c < COL_LIM) && !row_c[SW-1] && (row_c < ROW_LIM);
		end
	end

	// Skid register: catches the word leaving the last stage when the
	// output stalls, and holds the pipeline until it is taken.
	lud_pkg::src_t sk_col_q, sk_row_q;
	logic          sk_ins_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sk_v_q <= 1'b0;
		end else if (sk_v_q) begin
			if (mapped.ready) begin
				sk_v_q <= 1'b0;
			end
		end else if (vld_s14 && !mapped.ready) begin
			sk_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!sk_v_q) begin
			sk_col_q <= col_s14;
			sk_row_q <= row_s14;
			sk_ins_q <= ins_s14;
		end
	end

	assign mapped.valid      = sk_v_q || vld_s14;
	assign mapped.src_col    = sk_v_q ? sk_col_q : col_s14;
	assign mapped.src_row    = sk_v_q ? sk_row_q : row_s14;
	assign mapped.src_inside = sk_v_q ? sk_ins_q : ins_s14;

endmodule

FILE: sv/lud_norm.sv
// One normalization lane: (pix*256 - center) * 2^28 / focal, truncated toward
// zero and clamped to Q4.28, as a pipelined restoring divider. Uses lud_pkg.
module lud_norm (
	input  logic                        clk,
	input  logic                        en,
	input  logic [lud_pkg::PIX_W-1:0]   pix,
	input  logic [lud_pkg::FOC_W-1:0]   center,
	input  logic [lud_pkg::FOC_W-1:0]   focal,
	output lud_pkg::q_t                 q
);

	localparam int STEPS = lud_pkg::DIV_STEPS;
	localparam int FW    = lud_pkg::FOC_W;

	logic signed [FW:0] diff;
	logic [FW-1:0]      mag;
	logic [FW-1:0]      fdiv;
	logic               ovf;

	logic [FW-1:0]    rem_s [0:STEPS];
	logic [STEPS-1:0] quo_s [0:STEPS];
	logic [3:0]       low_s [0:STEPS];
	logic             neg_s [0:STEPS];
	logic             ovf_s [0:STEPS];

	// A zero focal length divides as one.
	assign fdiv = (focal == '0) ? FW'(1) : focal;

	always_comb begin
		diff = $signed({2'b00, pix, 8'h00}) - $signed({1'b0, center});
		mag  = diff[FW] ? FW'(-diff) : diff[FW-1:0];
		// The quotient reaches 2^32 exactly when |diff| >= 16 * focal.
		ovf  = {4'b0000, mag} >= {fdiv, 4'b0000};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {4'b0000, mag[FW-1:4]};
			low_s[0] <= mag[3:0];
			quo_s[0] <= '0;
			neg_s[0] <= diff[FW];
			ovf_s[0] <= ovf;
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic          bit_in;
		logic [FW:0]   trial;
		logic          ge;

		if (k < 4) begin : g_low
			assign bit_in = low_s[k][3-k];
		end else begin : g_zero
			assign bit_in = 1'b0;
		end

		assign trial = {rem_s[k], bit_in};
		assign ge    = trial >= {1'b0, fdiv};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? FW'(trial - {1'b0, fdiv}) : trial[FW-1:0];
				quo_s[k+1] <= {quo_s[k][STEPS-2:0], ge};
				low_s[k+1] <= low_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ovf_s[STEPS]) begin
				q <= neg_s[STEPS] ? lud_pkg::Q_MIN : lud_pkg::Q_MAX;
			end else if (!neg_s[STEPS]) begin
				q <= quo_s[STEPS][STEPS-1] ? lud_pkg::Q_MAX : $signed(quo_s[STEPS]);
			end else if (quo_s[STEPS] > 32'h8000_0000) begin
				q <= lud_pkg::Q_MIN;
			end else begin
				q <= $signed(-quo_s[STEPS]);
			end
		end
	end

endmodule
